### rtl/core/psrt_pkg.sv
// Shared constants, register indexes and the sine table generator for the point transform.
`default_nettype none

package psrt_pkg;

    localparam int FRAC_BITS_DEF  = 8;
    localparam int ANGLE_BITS_DEF = 12;

    localparam int COORD_W     = 32;
    localparam int ANGLE_REG_W = 12;
    localparam int CFG_IDX_W   = 2;

    localparam logic [COORD_W-1:0] SCALE_RESET = 32'd256;

    // pi/2 in Q30.
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROTATION_ANGLE = 2'd0,
        REG_SCALE_FACTOR   = 2'd1,
        REG_OFFSET_X       = 2'd2,
        REG_OFFSET_Y       = 2'd3
    } cfg_index_t;

    // Quarter-wave sine entry k: Q30 Taylor series with truncating steps,
    // then rounded half up to frac_bits fraction bits. Elaboration only.
    function automatic logic [63:0] quarter_sin(input int unsigned k, input int frac_bits,
                                                input int angle_bits);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x    = (64'(k) * HALF_PI_Q30) >> (angle_bits - 2);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            term = (term * x2) >> 30;
            case (n)
                1: term = term / 6;
                2: term = term / 20;
                3: term = term / 42;
                4: term = term / 72;
                5: term = term / 110;
                6: term = term / 156;
                default: term = term / 210;
            endcase
            if ((n % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = 64'sd0;
        end
        return ($unsigned(sum) + (64'd1 << (29 - frac_bits))) >> (30 - frac_bits);
    endfunction

endpackage

`default_nettype wire

### rtl/core/psrt_trig.sv
// Cosine and sine of the configured angle from a quarter-wave table, two register stages.
`default_nettype none

module psrt_trig
    import psrt_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic [ANGLE_REG_W-1:0]       angle,
    output logic signed [FRAC_BITS+1:0]       cos_val,
    output logic signed [FRAC_BITS+1:0]       sin_val
);

    localparam int QUARTER = 1 << (ANGLE_BITS - 2);
    localparam int ADDR_W  = ANGLE_BITS - 1;

    typedef logic [FRAC_BITS:0] mag_t;
    typedef mag_t rom_t [0:QUARTER];

    function automatic rom_t build_rom();
        rom_t r;
        for (int k = 0; k <= QUARTER; k++) begin
            r[k] = mag_t'(quarter_sin(k, FRAC_BITS, ANGLE_BITS));
        end
        return r;
    endfunction

    localparam rom_t SINE_ROM = build_rom();

    localparam logic [ADDR_W-1:0]     QUARTER_ADDR  = {1'b1, {(ANGLE_BITS - 2){1'b0}}};
    localparam logic [ANGLE_BITS-1:0] QUARTER_PHASE = {2'b01, {(ANGLE_BITS - 2){1'b0}}};

    logic [31:0]           angle_ext;
    logic [ANGLE_BITS-1:0] sin_phase;
    logic [ANGLE_BITS-1:0] cos_phase;
    logic [ADDR_W-1:0]     sin_addr;
    logic [ADDR_W-1:0]     cos_addr;

    mag_t sin_mag_reg;
    mag_t cos_mag_reg;
    logic sin_neg_reg;
    logic cos_neg_reg;
    logic signed [FRAC_BITS+1:0] sin_reg;
    logic signed [FRAC_BITS+1:0] cos_reg;
    logic signed [FRAC_BITS+1:0] sin_next;
    logic signed [FRAC_BITS+1:0] cos_next;

    // The angle wraps modulo one turn of the table.
    assign angle_ext = {{(32 - ANGLE_REG_W){1'b0}}, angle};
    assign sin_phase = angle_ext[ANGLE_BITS-1:0];
    assign cos_phase = sin_phase + QUARTER_PHASE;

    // Odd quadrants read the quarter wave backwards.
    always_comb begin
        sin_addr = {1'b0, sin_phase[ANGLE_BITS-3:0]};
        cos_addr = {1'b0, cos_phase[ANGLE_BITS-3:0]};
        if (sin_phase[ANGLE_BITS-2]) begin
            sin_addr = QUARTER_ADDR - {1'b0, sin_phase[ANGLE_BITS-3:0]};
        end
        if (cos_phase[ANGLE_BITS-2]) begin
            cos_addr = QUARTER_ADDR - {1'b0, cos_phase[ANGLE_BITS-3:0]};
        end
    end

    always_ff @(posedge aclk) begin
        sin_mag_reg <= SINE_ROM[sin_addr];
        cos_mag_reg <= SINE_ROM[cos_addr];
        sin_neg_reg <= sin_phase[ANGLE_BITS-1];
        cos_neg_reg <= cos_phase[ANGLE_BITS-1];
    end

    assign sin_next = sin_neg_reg ? -$signed({1'b0, sin_mag_reg}) : $signed({1'b0, sin_mag_reg});
    assign cos_next = cos_neg_reg ? -$signed({1'b0, cos_mag_reg}) : $signed({1'b0, cos_mag_reg});

    always_ff @(posedge aclk) begin
        sin_reg <= sin_next;
        cos_reg <= cos_next;
    end

    assign sin_val = sin_reg;
    assign cos_val = cos_reg;

endmodule

`default_nettype wire

### rtl/core/point_scale_rotate_translate.sv
// Four register stages: input, scale product, rotate product and output. Throughput:
// one point per cycle while m_ready does not stall the output, set by the pipeline of
// one scale multiply, one rotate multiply and one three-input add stage. Reset (aresetn
// low, synchronous) empties the pipeline and loads angle 0, scale 1.0 and zero offsets.
// Cosine and sine follow an angle write through the registers of psrt_trig.
`default_nettype none

module point_scale_rotate_translate
    import psrt_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_we,
    input  wire logic [CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [COORD_W-1:0]        cfg_wdata,
    input  wire logic                      s_valid,
    output logic                           s_ready,
    input  wire logic signed [COORD_W-1:0] s_point_x,
    input  wire logic signed [COORD_W-1:0] s_point_y,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic signed [COORD_W-1:0]      m_out_x,
    output logic signed [COORD_W-1:0]      m_out_y
);

    localparam int TRIG_W = FRAC_BITS + 2;
    localparam int PROD_W = 2 * COORD_W;
    localparam int ROT_W  = COORD_W + TRIG_W;

    logic [ANGLE_REG_W-1:0]      angle_reg;
    logic signed [COORD_W-1:0]   scale_reg;
    logic signed [COORD_W-1:0]   offset_x_reg;
    logic signed [COORD_W-1:0]   offset_y_reg;

    logic signed [TRIG_W-1:0]    cos_val;
    logic signed [TRIG_W-1:0]    sin_val;

    logic                        v1_reg, v2_reg, v3_reg, v4_reg;
    logic                        rdy1, rdy2, rdy3, rdy4;

    logic signed [COORD_W-1:0]   px_reg, py_reg;
    logic signed [PROD_W-1:0]    prod_x_reg, prod_y_reg;
    logic signed [PROD_W-1:0]    prod_x_next, prod_y_next;
    logic signed [COORD_W-1:0]   sx, sy;
    logic signed [ROT_W-1:0]     xc_reg, ys_reg, xs_reg, yc_reg;
    logic signed [ROT_W-1:0]     xc_next, ys_next, xs_next, yc_next;
    logic signed [COORD_W-1:0]   out_x_reg, out_y_reg;
    logic signed [COORD_W-1:0]   out_x_next, out_y_next;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_reg    <= '0;
            scale_reg    <= SCALE_RESET;
            offset_x_reg <= '0;
            offset_y_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index_t'(cfg_index))
                REG_ROTATION_ANGLE: angle_reg    <= cfg_wdata[ANGLE_REG_W-1:0];
                REG_SCALE_FACTOR:   scale_reg    <= cfg_wdata;
                REG_OFFSET_X:       offset_x_reg <= cfg_wdata;
                REG_OFFSET_Y:       offset_y_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    psrt_trig #(
        .FRAC_BITS  (FRAC_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_trig (
        .aclk    (aclk),
        .angle   (angle_reg),
        .cos_val (cos_val),
        .sin_val (sin_val)
    );

    // A stage takes new data when it is empty or its content moves on.
    assign rdy4    = !v4_reg || m_ready;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
        end
    end

    // Scale: full products; the fixed-point result is a slice of each.
    assign prod_x_next = px_reg * scale_reg;
    assign prod_y_next = py_reg * scale_reg;

    assign sx = prod_x_reg[FRAC_BITS+COORD_W-1:FRAC_BITS];
    assign sy = prod_y_reg[FRAC_BITS+COORD_W-1:FRAC_BITS];

    assign xc_next = sx * cos_val;
    assign ys_next = sy * sin_val;
    assign xs_next = sx * sin_val;
    assign yc_next = sy * cos_val;

    assign out_x_next = xc_reg[FRAC_BITS+COORD_W-1:FRAC_BITS]
                      - ys_reg[FRAC_BITS+COORD_W-1:FRAC_BITS] + offset_x_reg;
    assign out_y_next = xs_reg[FRAC_BITS+COORD_W-1:FRAC_BITS]
                      + yc_reg[FRAC_BITS+COORD_W-1:FRAC_BITS] + offset_y_reg;

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            px_reg <= s_point_x;
            py_reg <= s_point_y;
        end
        if (rdy2) begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
        end
        if (rdy3) begin
            xc_reg <= xc_next;
            ys_reg <= ys_next;
            xs_reg <= xs_next;
            yc_reg <= yc_next;
        end
        if (rdy4) begin
            out_x_reg <= out_x_next;
            out_y_reg <= out_y_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_out_x = out_x_reg;
    assign m_out_y = out_y_reg;

endmodule

`default_nettype wire

### tb/tb_point_scale_rotate_translate.sv
// Self-checking testbench for the scale, rotate and translate point pipeline.
module tb_point_scale_rotate_translate;
    timeunit 1ns;
    timeprecision 1ps;

    import psrt_pkg::*;

    localparam int FRAC_BITS  = 8;
    localparam int ANGLE_BITS = 12;

    localparam int unsigned QUARTER_TURN = 1 << (ANGLE_BITS - 2);
    localparam logic [63:0] HALF_PI_FIX30 = 64'd1686629713;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

    localparam int DRAIN_CYCLES   = 10;
    localparam int SEGMENTS       = 5;
    localparam int SEGMENT_POINTS = 133;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } coord_pair_t;

    logic                      aclk      = 1'b0;
    logic                      aresetn   = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [COORD_W-1:0]        cfg_wdata = '0;
    logic                      s_valid   = 1'b0;
    logic                      s_ready;
    logic signed [COORD_W-1:0] s_point_x = '0;
    logic signed [COORD_W-1:0] s_point_y = '0;
    logic                      m_valid;
    logic                      m_ready   = 1'b0;
    logic signed [COORD_W-1:0] m_out_x;
    logic signed [COORD_W-1:0] m_out_y;

    // Copy of the block's configuration used for prediction.
    logic [ANGLE_REG_W-1:0]    cur_angle    = '0;
    logic signed [COORD_W-1:0] cur_scale    = SCALE_RESET;
    logic signed [COORD_W-1:0] cur_offset_x = '0;
    logic signed [COORD_W-1:0] cur_offset_y = '0;

    coord_pair_t pending_points[$];
    coord_pair_t expected_points[$];

    int  points_queued   = 0;
    int  points_accepted = 0;
    int  results_seen    = 0;
    int  mismatches      = 0;
    int  sender_idle_pct = 0;
    int  recv_idle_pct   = 0;
    logic hold_sender    = 1'b0;
    logic point_fired    = 1'b0;

    point_scale_rotate_translate #(
        .FRAC_BITS (FRAC_BITS),
        .ANGLE_BITS(ANGLE_BITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_point_x(s_point_x),
        .s_point_y(s_point_y),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_out_x  (m_out_x),
        .m_out_y  (m_out_y)
    );

    always #5 aclk = ~aclk;

    // Quarter-wave sine in Q30 by a truncating series, rounded half up to FRAC_BITS.
    function automatic logic signed [COORD_W-1:0] quarter_sine(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] acc;
        x    = (64'(k) * HALF_PI_FIX30) / 64'(QUARTER_TURN);
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (int n = 1; n <= 7; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            if ((n % 2) == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = 64'sd0;
        end
        x = ($unsigned(acc) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS);
        return x[COORD_W-1:0];
    endfunction

    // Full wave from the quarter by mirroring in odd quadrants and negating in the lower half.
    function automatic logic signed [COORD_W-1:0] sine_of(input logic [ANGLE_BITS-1:0] p);
        int unsigned               r;
        logic signed [COORD_W-1:0] mag;
        r   = int'(p[ANGLE_BITS-3:0]);
        mag = p[ANGLE_BITS-2] ? quarter_sine(QUARTER_TURN - r) : quarter_sine(r);
        return p[ANGLE_BITS-1] ? -mag : mag;
    endfunction

    function automatic logic signed [COORD_W-1:0] fix_mul(input logic signed [COORD_W-1:0] a,
                                                          input logic signed [COORD_W-1:0] b);
        logic signed [63:0] prod;
        logic signed [63:0] shifted;
        prod    = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
        shifted = prod >>> FRAC_BITS;
        return shifted[COORD_W-1:0];
    endfunction

    function automatic coord_pair_t transform_point(input coord_pair_t pt);
        logic [ANGLE_BITS-1:0]     ang;
        logic signed [COORD_W-1:0] sn;
        logic signed [COORD_W-1:0] cs;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        coord_pair_t               res;
        ang   = cur_angle[ANGLE_BITS-1:0];
        sn    = sine_of(ang);
        cs    = sine_of(ang + ANGLE_BITS'(QUARTER_TURN));
        sx    = fix_mul(pt.x, cur_scale);
        sy    = fix_mul(pt.y, cur_scale);
        res.x = fix_mul(sx, cs) - fix_mul(sy, sn) + cur_offset_x;
        res.y = fix_mul(sx, sn) + fix_mul(sy, cs) + cur_offset_y;
        return res;
    endfunction

    function automatic logic signed [COORD_W-1:0] random_coord();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(4095)) - 2048;
            2: return $urandom_range(1) ? COORD_MAX - $urandom_range(3)
                                         : COORD_MIN + $urandom_range(3);
            default: return $signed($urandom_range(32'h1F_FFFF)) - 32'sh10_0000;
        endcase
    endfunction

    function automatic logic signed [COORD_W-1:0] random_scale();
        logic signed [COORD_W-1:0] pow;
        case ($urandom_range(3))
            0: return $urandom;
            1: return $signed($urandom_range(1023)) - 512;
            2: return 256 + $signed($urandom_range(63)) - 32;
            default: begin
                pow = 32'sd1 <<< $urandom_range(16);
                return $urandom_range(1) ? -pow : pow;
            end
        endcase
    endfunction

    // Driver: a new point goes out once the previous one has been transferred.
    always @(negedge aclk) begin
        coord_pair_t next_pt;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || point_fired) begin
            if (hold_sender || pending_points.size() == 0 ||
                $urandom_range(99) < sender_idle_pct) begin
                s_valid <= 1'b0;
            end else begin
                next_pt   = pending_points.pop_front();
                s_valid   <= 1'b1;
                s_point_x <= next_pt.x;
                s_point_y <= next_pt.y;
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Monitor: predicts each accepted point and checks each result transfer.
    always @(posedge aclk) begin
        coord_pair_t want;
        point_fired <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_points.push_back(transform_point('{x: s_point_x, y: s_point_y}));
                points_accepted <= points_accepted + 1;
            end
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (expected_points.size() == 0) begin
                    mismatches = mismatches + 1;
                    $display("%0t: unexpected result x=%0d y=%0d", $time, m_out_x, m_out_y);
                end else begin
                    want = expected_points.pop_front();
                    if (m_out_x !== want.x) begin
                        mismatches = mismatches + 1;
                        $display("%0t: out_x expected %0d actual %0d",
                                 $time, want.x, m_out_x);
                    end
                    if (m_out_y !== want.y) begin
                        mismatches = mismatches + 1;
                        $display("%0t: out_y expected %0d actual %0d",
                                 $time, want.y, m_out_y);
                    end
                end
            end
        end
    end

    task automatic queue_point(input logic signed [COORD_W-1:0] x,
                               input logic signed [COORD_W-1:0] y);
        pending_points.push_back('{x: x, y: y});
        points_queued++;
    endtask

    task automatic wait_all_results();
        while (results_seen != points_queued) begin
            @(negedge aclk);
        end
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [COORD_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_ROTATION_ANGLE: cur_angle    = data[ANGLE_REG_W-1:0];
            REG_SCALE_FACTOR:   cur_scale    = data;
            REG_OFFSET_X:       cur_offset_x = data;
            REG_OFFSET_Y:       cur_offset_y = data;
            default: ;
        endcase
    endtask

    // Registers change only with the pipeline empty; the task then waits for the sine table to settle.
    task automatic reconfigure(input logic [COORD_W-1:0] angle_word,
                               input logic [COORD_W-1:0] scale,
                               input logic [COORD_W-1:0] off_x,
                               input logic [COORD_W-1:0] off_y);
        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        write_reg(REG_ROTATION_ANGLE, angle_word);
        write_reg(REG_SCALE_FACTOR, scale);
        write_reg(REG_OFFSET_X, off_x);
        write_reg(REG_OFFSET_Y, off_y);
        @(negedge aclk);
        cfg_we <= 1'b0;
        repeat (4) @(negedge aclk);
        @(posedge aclk);
    endtask

    initial begin
        sender_idle_pct = 9;
        recv_idle_pct   = 83;
        repeat (4) @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset configuration: identity scale, no rotation, no offset.
        queue_point(0, 0);
        queue_point(COORD_MAX, COORD_MAX);
        queue_point(COORD_MIN, COORD_MIN);
        queue_point(256, -256);
        queue_point(COORD_MIN, COORD_MAX);

        // Quarter turn with the largest scale and extreme offsets, so that products of large coordinates wrap.
        reconfigure(QUARTER_TURN, COORD_MAX, COORD_MAX, COORD_MIN);
        queue_point(256, 0);
        queue_point(COORD_MAX, COORD_MIN);
        queue_point(-1, 1);

        // Half turn; the upper bits of the angle word must be ignored.
        reconfigure(32'hFFFF_F000 | (2 * QUARTER_TURN), COORD_MIN, COORD_MIN, COORD_MAX);
        queue_point(1, 1);
        queue_point(COORD_MAX, COORD_MAX);
        queue_point(-1, -1);

        reconfigure(3 * QUARTER_TURN, -256, 32'h1234_5678, -256);
        queue_point(512, -768);
        queue_point(COORD_MIN, 0);
        queue_point(0, COORD_MAX);

        // Largest angle with the smallest nonzero scale.
        reconfigure(32'h0000_0FFF, 1, 0, 0);
        queue_point(COORD_MAX, COORD_MIN);
        queue_point(32'sh0001_0000, -32'sh0001_0000);
        queue_point(255, -255);

        // Zero scale leaves only the offsets.
        reconfigure(QUARTER_TURN / 2, 0, -1, 1);
        queue_point(COORD_MAX, COORD_MIN);
        queue_point(12345, -6789);

        reconfigure(0, SCALE_RESET, 0, 0);
        queue_point(32'sh0000_FFFF, 32'shFFFF_0001);
        queue_point(-32'sd2, 32'sd3);

        for (int phase = 0; phase < 3; phase++) begin
            for (int seg = 0; seg < SEGMENTS; seg++) begin
                reconfigure($urandom, random_scale(),
                            $urandom_range(1) ? $urandom : random_coord(),
                            $urandom_range(1) ? $urandom : random_coord());
                if (seg == 0) begin
                    case (phase)
                        0: begin
                            sender_idle_pct = 9;
                            recv_idle_pct   = 83;
                        end
                        1: begin
                            sender_idle_pct = 83;
                            recv_idle_pct   = 9;
                        end
                        default: begin
                            sender_idle_pct = 0;
                            recv_idle_pct   = 0;
                        end
                    endcase
                end
                for (int i = 0; i < SEGMENT_POINTS; i++) begin
                    queue_point(random_coord(), random_coord());
                end
                if (phase == 2 && seg == 2) begin
                    // Stall the sender until the pipeline has emptied completely.
                    while (pending_points.size() > SEGMENT_POINTS / 2) begin
                        @(posedge aclk);
                    end
                    hold_sender = 1'b1;
                    @(negedge aclk);
                    while (s_valid || results_seen != points_accepted) begin
                        @(negedge aclk);
                    end
                    @(posedge aclk);
                    hold_sender = 1'b0;
                end
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
